### rtl/assert_macros.svh
// Assertion helpers used by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/mted_pkg.sv
`default_nettype none

package mted_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned CNT_W   = 12;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned LEFT_W  = 2;

   localparam logic [MODE_W-1:0] MODE_ASCII = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UTF8  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GB    = 2'd2;

   localparam logic [STAT_W-1:0] STAT_CHAR    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_END     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

   localparam logic CSR_MODE      = 1'b0;
   localparam logic CSR_MAX_CHARS = 1'b1;

   localparam logic [MODE_W-1:0] MODE_RESET      = MODE_UTF8;
   localparam logic [CNT_W-1:0]  MAX_CHARS_RESET = 12'd4095;

   localparam logic [BYTE_W-1:0] GB_LOW  = 8'hA1;
   localparam logic [BYTE_W-1:0] GB_HIGH = 8'hFE;

   // Per-string decoder state.
   typedef struct packed {
      logic [LEFT_W-1:0] bytes_left;
      logic [CP_W-1:0]   partial_value;
      logic              dropping;
      logic [CNT_W-1:0]  char_count;
   } dec_state_type;

   // Configuration seen by the decode step.
   typedef struct packed {
      logic [MODE_W-1:0] encoding_mode;
      logic [CNT_W-1:0]  max_chars;
   } cfg_type;

   // One step's result.
   typedef struct packed {
      logic              emit;
      logic [CP_W-1:0]   code_point;
      logic [STAT_W-1:0] status;
   } result_type;

endpackage

`default_nettype wire

### rtl/mted_cfg.sv
`default_nettype none

module mted_cfg
   import mted_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [CNT_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [MODE_W-1:0] mode_ff;
   logic [CNT_W-1:0]  max_chars_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_MAX_CHARS: max_chars_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.encoding_mode = mode_ff;
   assign cfg.max_chars     = max_chars_ff;

endmodule

`default_nettype wire

### rtl/mted_step.sv
`default_nettype none

module mted_step
   import mted_pkg::*;
(
   input  wire cfg_type           cfg,
   input  wire dec_state_type     cur,
   input  wire logic [BYTE_W-1:0] data_byte,
   output dec_state_type          nxt,
   output result_type             res
);

   logic              gb;
   logic              cont_ok;
   logic              gb_range;
   logic [CP_W-1:0]   acc;
   logic [CNT_W-1:0]  count_inc;

   assign gb       = (cfg.encoding_mode == MODE_GB);
   assign gb_range = (data_byte >= GB_LOW) && (data_byte <= GB_HIGH);
   assign count_inc = (cur.char_count == '1) ? cur.char_count : cur.char_count + 1'b1;

   always_comb begin
      if (gb) begin
         cont_ok = gb_range;
         acc     = {cur.partial_value[CP_W-BYTE_W-1:0], data_byte};
      end else begin
         cont_ok = (data_byte[7:6] == 2'b10);
         acc     = {cur.partial_value[CP_W-7:0], data_byte[5:0]};
      end
   end

   always_comb begin
      nxt            = cur;
      res.emit       = 1'b0;
      res.code_point = '0;
      res.status     = STAT_CHAR;
      if (data_byte == '0) begin
         // terminator: closes the string either way
         res.emit   = 1'b1;
         res.status = ((cur.bytes_left != '0) && !cur.dropping) ? STAT_INVALID : STAT_END;
         nxt        = '0;
      end else if (cur.dropping) begin
         nxt = cur;
      end else if (cur.bytes_left != '0) begin
         if (!cont_ok) begin
            res.emit          = 1'b1;
            res.status        = STAT_INVALID;
            nxt.bytes_left    = '0;
            nxt.partial_value = '0;
            nxt.dropping      = 1'b1;
         end else if (cur.bytes_left == LEFT_W'(1)) begin
            res.emit          = 1'b1;
            res.code_point    = acc;
            nxt.bytes_left    = '0;
            nxt.partial_value = '0;
            nxt.char_count    = count_inc;
         end else begin
            nxt.bytes_left    = cur.bytes_left - 1'b1;
            nxt.partial_value = acc;
         end
      end else if (cur.char_count >= cfg.max_chars) begin
         nxt = cur;
      end else if (!data_byte[7]) begin
         res.emit       = 1'b1;
         res.code_point = CP_W'(data_byte);
         nxt.char_count = count_inc;
      end else if (cfg.encoding_mode == MODE_UTF8) begin
         if (data_byte[7:5] == 3'b110) begin
            nxt.bytes_left    = LEFT_W'(1);
            nxt.partial_value = CP_W'(data_byte[4:0]);
         end else if (data_byte[7:4] == 4'b1110) begin
            nxt.bytes_left    = LEFT_W'(2);
            nxt.partial_value = CP_W'(data_byte[3:0]);
         end else if (data_byte[7:3] == 5'b11110) begin
            nxt.bytes_left    = LEFT_W'(3);
            nxt.partial_value = CP_W'(data_byte[2:0]);
         end else begin
            res.emit     = 1'b1;
            res.status   = STAT_INVALID;
            nxt.dropping = 1'b1;
         end
      end else if (gb && gb_range) begin
         nxt.bytes_left    = LEFT_W'(1);
         nxt.partial_value = CP_W'(data_byte);
      end else begin
         // bad gb2312 lead, or high byte in ascii mode
         res.emit     = 1'b1;
         res.status   = STAT_INVALID;
         nxt.dropping = 1'b1;
      end
   end

endmodule

`default_nettype wire

### rtl/multi_encoding_text_decoder.sv
// Channel  Direction  Ports                                   Handshake
// req      in         req_data_byte[7:0]                      req_valid / req_ready
// rsp      out        rsp_code_point[20:0], rsp_status[1:0]   rsp_valid / rsp_ready
// csr      in         csr_index, csr_wdata[11:0]              csr_valid / csr_ready
//
// One byte per cycle sustained while rsp is not stalled. A byte is held in the input
// register, is decoded against the string state and lands in the result register:
// rsp_valid rises as the result register is loaded. Bytes that give no result only
// update the state.
// Synchronous reset sets utf-8 mode, a limit of 4095 and clears all string state.
// A stalled rsp holds the input register; req_ready drops only while both are full.
`default_nettype none
`include "assert_macros.svh"

module multi_encoding_text_decoder
   import mted_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [CP_W-1:0]        rsp_code_point,
   output logic [STAT_W-1:0]      rsp_status,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [CNT_W-1:0]  csr_wdata
);

   cfg_type           cfg;
   dec_state_type     state_ff;
   dec_state_type     state_in;
   result_type        res;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff;
   logic [CP_W-1:0]   rsp_cp_ff;
   logic [STAT_W-1:0] rsp_stat_ff;
   logic              advance;

   mted_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mted_step u_step (
      .cfg       (cfg),
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .nxt       (state_in),
      .res       (res)
   );

   // byte in the input register moves on when the result slot is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && res.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance && res.emit) begin
         rsp_cp_ff   <= res.code_point;
         rsp_stat_ff <= res.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;
   assign rsp_status     = rsp_stat_ff;

   `ASSERT_IMPL(a_drop_no_seq, clock, reset, state_ff.dropping, state_ff.bytes_left == '0)
   `ASSERT_IMPL(a_noncp_zero, clock, reset, rsp_valid_ff && (rsp_stat_ff != STAT_CHAR), rsp_cp_ff == '0)
   `ASSERT_NEXT(a_term_clears, clock, reset, advance && (in_byte_ff == '0), state_ff == '0)
   `ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire
